// ===== rtl/i2ctrf_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_pkg: shared types and constants
// Bus event codes, controller states and the memory request bundle used by
// the I2C target register file.
// ----------------------------------------------------------------------------
package i2ctrf_pkg;

  // Default number of byte entries in the register file.
  localparam int BUFFER_DEPTH_DEF = 128;

  // Byte sent when the pointer is past the end of the register file.
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // Bus events, one per transaction on the input channel.
  typedef enum logic [2:0] {
    CMD_ADDRESS    = 3'd0,
    CMD_BYTE       = 3'd1,
    CMD_MASTER_ACK = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_BUS_ERROR  = 3'd4
  } i2ctrf_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } i2ctrf_state_t;

  // Request from the controller to the storage.
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] rd_addr;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
  } i2ctrf_mem_req_t;

endpackage

// ===== rtl/i2ctrf_if.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_if: channel interfaces
// Valid/ready channels for bus events in and responses out.
// ----------------------------------------------------------------------------
interface i2ctrf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface i2ctrf_out_if;
  logic       valid;
  logic       ready;
  logic       ack;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       busy_res;

  modport source (output valid, output ack, output tx_valid, output tx_byte,
                  output busy_res, input ready);
  modport sink   (input valid, input ack, input tx_valid, input tx_byte,
                  input busy_res, output ready);
endinterface

// ===== rtl/i2c_target_register_file_core.sv =====
// ----------------------------------------------------------------------------
// i2c_target_register_file_core: I2C target register file, event level
// Byte-addressed register file with auto-incrementing pointer, driven by
// decoded bus events; one response transaction per event transaction.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                               Handshake
//   in_ch     in         command[2:0], data_byte[7:0]          valid/ready
//   out_ch    out        ack, tx_valid, tx_byte[7:0], busy_res valid/ready
//
// Each event is taken in the idle state, where the storage is read at the
// current pointer when it is in range, and is then completed in the execute
// state, where the controller updates the pointer and transfer state, writes
// a received byte and loads the response register.
// A new event is accepted in the cycle after the response is loaded, even
// while that response still waits on out_ch; no event is accepted while the
// previous one is still in the execute state.
// If out_ch stalls with a response pending, the next event is held in the
// execute state until the response register drains.
// Reset (rst_n low, synchronous) clears the pointer, the transfer flags and
// all entry valid bits at once; unwritten entries read as zero, so no
// clearing pass is needed and events are accepted right after reset.
//
module i2c_target_register_file_core #(
  parameter int BUFFER_DEPTH = i2ctrf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  i2ctrf_in_if.sink     in_ch,
  i2ctrf_out_if.source  out_ch
);

  // Storage request from the controller and the registered read data back.
  i2ctrf_pkg::i2ctrf_mem_req_t mem_req;
  logic [7:0]                  mem_rd_data;

  // Event sequencing, pointer and transfer state, response register.
  i2ctrf_ctrl #(
    .DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_command   (in_ch.command),
    .in_data_byte (in_ch.data_byte),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_ack      (out_ch.ack),
    .out_tx_valid (out_ch.tx_valid),
    .out_tx_byte  (out_ch.tx_byte),
    .out_busy_res (out_ch.busy_res),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data)
  );

  // Byte storage with per-entry valid bits standing in for the zero reset.
  i2ctrf_mem #(
    .DEPTH (BUFFER_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== rtl/i2ctrf_mem.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_mem: register file storage
// Synchronous single-write, single-read byte memory with registered read
// data. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module i2ctrf_mem #(
  parameter int DEPTH = i2ctrf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  i2ctrf_pkg::i2ctrf_mem_req_t req,
  output logic [7:0]                  rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem_r[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[req.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : 8'h00;

endmodule

// ===== rtl/i2ctrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_ctrl: bus event controller
// Takes one event, reads the entry at the pointer, then updates the pointer
// and transfer state, writes received bytes and loads the response register.
// ----------------------------------------------------------------------------
module i2ctrf_ctrl #(
  parameter int DEPTH = i2ctrf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_command,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ack,
  output logic                        out_tx_valid,
  output logic [7:0]                  out_tx_byte,
  output logic                        out_busy_res,
  output i2ctrf_pkg::i2ctrf_mem_req_t mem_req,
  input  logic [7:0]                  mem_rd_data
);

  localparam logic [7:0] DEPTH_B = 8'(DEPTH);

  i2ctrf_pkg::i2ctrf_state_t state_r, state_nxt;
  logic [2:0] cmd_r;
  logic [7:0] data_r;
  logic [7:0] ptr_r, ptr_nxt;
  logic       loaded_r, loaded_nxt;
  logic       xfer_r, xfer_nxt;
  logic       oval_r, oval_nxt;
  logic       oack_r, oack_nxt;
  logic       otxv_r, otxv_nxt;
  logic [7:0] otx_r, otx_nxt;
  logic       obusy_r, obusy_nxt;
  logic       accept;
  logic       done;
  logic       in_range;

  assign accept   = in_valid && in_ready;
  assign in_range = (ptr_r < DEPTH_B);
  // The result register can take a new response when empty or being drained.
  assign done     = (state_r == i2ctrf_pkg::ST_EXEC) && (!oval_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    loaded_nxt      = loaded_r;
    xfer_nxt        = xfer_r;
    oval_nxt        = oval_r && !out_ready;
    oack_nxt        = oack_r;
    otxv_nxt        = otxv_r;
    otx_nxt         = otx_r;
    obusy_nxt       = obusy_r;
    in_ready        = rst_n && (state_r == i2ctrf_pkg::ST_IDLE);
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = ptr_r;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = ptr_r;
    mem_req.wr_data = data_r;

    case (state_r)
      i2ctrf_pkg::ST_IDLE: begin
        if (accept) begin
          // The entry at the pointer is fetched for every event while the pointer is in range; only reads use it.
          mem_req.rd_en = in_range;
          state_nxt     = i2ctrf_pkg::ST_EXEC;
        end
      end
      i2ctrf_pkg::ST_EXEC: begin
        if (done) begin
          oack_nxt  = 1'b0;
          otxv_nxt  = 1'b0;
          otx_nxt   = 8'h00;
          case (i2ctrf_pkg::i2ctrf_cmd_t'(cmd_r))
            i2ctrf_pkg::CMD_ADDRESS: begin
              oack_nxt = 1'b1;
              xfer_nxt = 1'b1;
              if (data_r[0]) begin
                otxv_nxt = 1'b1;
                if (in_range) begin
                  otx_nxt = mem_rd_data;
                  ptr_nxt = ptr_r + 8'd1;
                end else begin
                  otx_nxt = i2ctrf_pkg::FILL_BYTE;
                end
              end else begin
                loaded_nxt = 1'b0;
              end
            end
            i2ctrf_pkg::CMD_BYTE: begin
              if (!loaded_r) begin
                if (data_r < DEPTH_B) begin
                  ptr_nxt    = data_r;
                  loaded_nxt = 1'b1;
                  oack_nxt   = 1'b1;
                end
              end else if (in_range) begin
                mem_req.wr_en = 1'b1;
                ptr_nxt       = ptr_r + 8'd1;
                oack_nxt      = 1'b1;
              end
            end
            i2ctrf_pkg::CMD_MASTER_ACK: begin
              otxv_nxt = 1'b1;
              if (in_range) begin
                otx_nxt = mem_rd_data;
                ptr_nxt = ptr_r + 8'd1;
              end else begin
                otx_nxt = i2ctrf_pkg::FILL_BYTE;
              end
            end
            i2ctrf_pkg::CMD_STOP,
            i2ctrf_pkg::CMD_BUS_ERROR: begin
              xfer_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          obusy_nxt = xfer_nxt;
          oval_nxt  = 1'b1;
          state_nxt = i2ctrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = i2ctrf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= i2ctrf_pkg::ST_IDLE;
      ptr_r    <= 8'h00;
      loaded_r <= 1'b0;
      xfer_r   <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      loaded_r <= loaded_nxt;
      xfer_r   <= xfer_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      data_r <= in_data_byte;
    end
    oack_r  <= oack_nxt;
    otxv_r  <= otxv_nxt;
    otx_r   <= otx_nxt;
    obusy_r <= obusy_nxt;
  end

  assign out_valid    = oval_r;
  assign out_ack      = oack_r;
  assign out_tx_valid = otxv_r;
  assign out_tx_byte  = otx_r;
  assign out_busy_res = obusy_r;

endmodule

// ===== rtl/i2ctrf_checker.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_checker: port-level checks
// Watches the channels of the register file core and flags ordering and
// response encoding errors.
// ----------------------------------------------------------------------------
module i2ctrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_ack,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_busy_res
);

  // A stalled response keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ack) &&
      $stable(out_tx_valid) && $stable(out_tx_byte) && $stable(out_busy_res))
    else $error("response changed while stalled");

  // Events are processed one at a time: no accept right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event accepted while previous still in process");

  // A fresh response only follows an accepted event: the event is registered,
  // then the response is loaded from the execute state.
  a_resp_after_event: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("response without a preceding event");

  // No byte is presented unless it is loaded for transmission.
  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'h00)
    else $error("tx_byte nonzero without tx_valid");

  // An acknowledged read address always leaves a transfer in progress.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack && out_tx_valid |-> out_busy_res)
    else $error("acknowledged read without transfer in progress");

endmodule

bind i2c_target_register_file_core i2ctrf_checker u_i2ctrf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_ack      (out_ch.ack),
  .out_tx_valid (out_ch.tx_valid),
  .out_tx_byte  (out_ch.tx_byte),
  .out_busy_res (out_ch.busy_res)
);
